// ===== src/twwc_pkg.sv =====
// ----------------------------------------------------------------------------
// twwc_pkg
// shared types, codes and constants of the word wrap cell emitter
// ----------------------------------------------------------------------------
package twwc_pkg;

  localparam int BUF_DEPTH_DEF = 16;
  localparam int TAB_STOP_DEF  = 8;

  localparam logic [20:0] CH_NL     = 21'd10;
  localparam logic [20:0] CH_TAB    = 21'd9;
  localparam logic [20:0] CH_HYPHEN = 21'd45;
  localparam logic [20:0] CH_SPACE  = 21'd32;

  localparam logic [9:0] COL_MAX = 10'd1023;

  // cell kinds; the marker kind appears on the output channel only
  localparam logic [2:0] K_ORD   = 3'd0;
  localparam logic [2:0] K_NL    = 3'd1;
  localparam logic [2:0] K_BLANK = 3'd2;
  localparam logic [2:0] K_END   = 3'd3;
  localparam logic [2:0] K_MARK  = 3'd4;

  // configuration register indexes
  localparam logic [0:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [0:0] REG_INTERVAL   = 1'd1;

  typedef struct packed {
    logic [20:0] code;
    logic [1:0]  width;
    logic [7:0]  color;
    logic [31:0] link;
  } slot_t;

  // one classified transaction between front and back
  typedef struct packed {
    logic        is_end;
    logic [1:0]  kind;
    logic [20:0] code;
    logic [1:0]  width;
    logic [7:0]  color;
    logic [31:0] link;
    logic [31:0] pos;
  } entry_t;

  typedef struct packed {
    logic [4:0] fill;
    logic       busy;
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_MARK, S_ROUTE, S_BLANK, S_TOP, S_LOOK,
    S_DECIDE, S_BRK, S_CELL, S_POST, S_FINAL, S_ENDC
  } state_t;

  function automatic logic is_ws(input logic [20:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
  endfunction

endpackage

// ===== src/twwc_front.sv =====
// ----------------------------------------------------------------------------
// twwc_front
// accepts input cells, classifies them and queues them for the back part
// ----------------------------------------------------------------------------
module twwc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          cell_kind,
  input  logic [20:0]         code_point,
  input  logic [1:0]          cell_width,
  input  logic [7:0]          cell_color,
  input  logic [31:0]         cell_link,
  input  logic [31:0]         doc_position,
  output logic                q_valid,
  output twwc_pkg::entry_t    q_data,
  input  logic                q_pop
);

  twwc_pkg::entry_t slot0, slot1, cls;
  logic [1:0] count;
  logic push;

  // end cells keep their fields; code ten on other cells makes a bare newline
  always_comb begin
    cls.is_end = (cell_kind == twwc_pkg::K_END[1:0]);
    cls.kind   = cell_kind;
    cls.code   = code_point;
    cls.width  = cell_width;
    cls.color  = cell_color;
    cls.link   = cell_link;
    cls.pos    = doc_position;
    if (cls.is_end) begin
      cls.kind = twwc_pkg::K_NL[1:0];
    end else if (code_point == twwc_pkg::CH_NL) begin
      cls.kind  = twwc_pkg::K_NL[1:0];
      cls.code  = '0;
      cls.width = '0;
      cls.color = '0;
      cls.link  = '0;
    end
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = slot0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      slot0 <= slot1;
      if (push && count == 2'd1) slot0 <= cls;
      if (push && count == 2'd2) slot1 <= cls;
    end else if (push) begin
      if (count == 2'd0) slot0 <= cls;
      else slot1 <= cls;
    end
  end

endmodule

// ===== src/twwc_back.sv =====
// ----------------------------------------------------------------------------
// twwc_back
// buffers cells, runs the wrapping flush and drives the output register
// ----------------------------------------------------------------------------
module twwc_back #(
  parameter int BUF_DEPTH = twwc_pkg::BUF_DEPTH_DEF,
  parameter int TAB_STOP  = twwc_pkg::TAB_STOP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  twwc_pkg::entry_t  q_data,
  output logic              q_pop,
  input  logic [9:0]        line_width,
  input  logic [15:0]       reset_interval,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_kind,
  output logic [31:0]       out_code,
  output logic [3:0]        out_width,
  output logic [7:0]        out_color,
  output logic [31:0]       out_link,
  output logic              out_last,
  output twwc_pkg::status_t status
);

  localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam int IW = 5;
  localparam logic [IW-1:0] DEPTH_C = IW'(BUF_DEPTH);
  localparam logic [3:0] TS_C = 4'(TAB_STOP);
  localparam logic [3:0] SAT_MOD = 4'(1023 % TAB_STOP);

  twwc_pkg::state_t state, state_next;
  twwc_pkg::slot_t  buf_q [BUF_DEPTH];
  twwc_pkg::slot_t  rd;
  twwc_pkg::entry_t ent;

  logic [IW-1:0] fill, i, j, nxt, rd_addr;
  logic [9:0]  column;
  logic [3:0]  colm, xm;
  logic [11:0] x;
  logic [7:0]  s;
  logic [31:0] sent, sar;
  logic        skip;

  logic        can_emit, emit, store_case, mark_due, brk, rd_tab;
  logic [2:0]  e_kind;
  logic [31:0] e_code, e_link;
  logic [3:0]  e_width, cell_w;
  logic [7:0]  e_color;
  logic        e_last;
  logic [11:0] x_cell, x_fin;

  // running column modulo the tab stop, for widths of at most a few columns
  function automatic logic [3:0] mod_add(input logic [3:0] m, input logic [3:0] w);
    logic [4:0] t;
    t = {1'b0, m} + {1'b0, w};
    for (int k = 0; k < 4; k++) begin
      if (t >= {1'b0, TS_C}) t = t - {1'b0, TS_C};
    end
    return t[3:0];
  endfunction

  assign can_emit   = !out_valid || !out_stall;
  assign store_case = !ent.is_end && ent.kind == twwc_pkg::K_ORD[1:0] && fill < DEPTH_C;
  assign mark_due   = (sent != 32'd0) && ((sent - sar) >= {16'd0, reset_interval});
  assign rd_addr    = (state == twwc_pkg::S_CELL) ? i : j;
  assign rd         = buf_q[rd_addr[AW-1:0]];
  assign rd_tab     = (rd.code == twwc_pkg::CH_TAB);
  assign brk        = ({2'd0, s} <= {2'd0, line_width}) &&
                      ((x + {4'd0, s}) >= {2'd0, line_width});
  assign cell_w     = rd_tab ? (TS_C - xm) : {2'd0, rd.width};
  assign x_cell     = x + {8'd0, cell_w};
  assign x_fin      = (ent.kind == twwc_pkg::K_NL[1:0]) ? 12'd0 :
                      (ent.is_end ? x : x + {10'd0, ent.width});
  assign q_pop      = (state == twwc_pkg::S_IDLE) && q_valid;
  assign status.fill = fill;
  assign status.busy = (state != twwc_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      twwc_pkg::S_IDLE:   if (q_valid) state_next = twwc_pkg::S_CHECK;
      twwc_pkg::S_CHECK:  state_next = mark_due ? twwc_pkg::S_MARK : twwc_pkg::S_ROUTE;
      twwc_pkg::S_MARK:   if (can_emit) state_next = twwc_pkg::S_ROUTE;
      twwc_pkg::S_ROUTE: begin
        if (!ent.is_end && ent.kind == twwc_pkg::K_BLANK[1:0]) state_next = twwc_pkg::S_BLANK;
        else if (store_case) state_next = twwc_pkg::S_IDLE;
        else state_next = twwc_pkg::S_TOP;
      end
      twwc_pkg::S_BLANK:  if (can_emit) state_next = twwc_pkg::S_IDLE;
      twwc_pkg::S_TOP: begin
        if (i >= fill) state_next = twwc_pkg::S_FINAL;
        else if (i >= nxt) state_next = twwc_pkg::S_LOOK;
        else state_next = twwc_pkg::S_CELL;
      end
      twwc_pkg::S_LOOK: begin
        if (j >= fill || rd.code == twwc_pkg::CH_HYPHEN || twwc_pkg::is_ws(rd.code)) begin
          state_next = twwc_pkg::S_DECIDE;
        end
      end
      twwc_pkg::S_DECIDE: state_next = brk ? twwc_pkg::S_BRK : twwc_pkg::S_CELL;
      twwc_pkg::S_BRK:    if (can_emit) state_next = skip ? twwc_pkg::S_TOP : twwc_pkg::S_CELL;
      twwc_pkg::S_CELL: begin
        if (can_emit) begin
          state_next = (x_cell >= {2'd0, line_width}) ? twwc_pkg::S_POST : twwc_pkg::S_TOP;
        end
      end
      twwc_pkg::S_POST:   if (can_emit) state_next = twwc_pkg::S_TOP;
      twwc_pkg::S_FINAL: begin
        if (can_emit) state_next = ent.is_end ? twwc_pkg::S_ENDC : twwc_pkg::S_IDLE;
      end
      twwc_pkg::S_ENDC:   if (can_emit) state_next = twwc_pkg::S_IDLE;
      default:            state_next = twwc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    emit    = 1'b0;
    e_kind  = twwc_pkg::K_NL;
    e_code  = '0;
    e_width = '0;
    e_color = '0;
    e_link  = '0;
    e_last  = 1'b0;
    case (state)
      twwc_pkg::S_MARK: begin
        emit   = can_emit;
        e_kind = twwc_pkg::K_MARK;
        e_code = ent.is_end ? {27'd0, fill} : ent.pos;
        e_link = sent;
        e_last = store_case;
      end
      twwc_pkg::S_BLANK: begin
        emit    = can_emit;
        e_kind  = twwc_pkg::K_BLANK;
        e_code  = {11'd0, ent.code};
        e_width = {2'd0, ent.width};
        e_color = ent.color;
        e_link  = ent.link;
        e_last  = 1'b1;
      end
      twwc_pkg::S_BRK, twwc_pkg::S_POST: begin
        emit = can_emit;
      end
      twwc_pkg::S_CELL: begin
        emit    = can_emit;
        e_kind  = twwc_pkg::K_ORD;
        e_code  = rd_tab ? {11'd0, twwc_pkg::CH_SPACE} : {11'd0, rd.code};
        e_width = cell_w;
        e_color = rd.color;
        e_link  = rd.link;
      end
      twwc_pkg::S_FINAL: begin
        emit   = can_emit;
        e_kind = {1'b0, ent.kind};
        e_last = !ent.is_end;
        if (!ent.is_end) begin
          e_code  = {11'd0, ent.code};
          e_width = {2'd0, ent.width};
          e_color = ent.color;
          e_link  = ent.link;
        end
      end
      twwc_pkg::S_ENDC: begin
        emit    = can_emit;
        e_kind  = twwc_pkg::K_END;
        e_code  = {11'd0, ent.code};
        e_width = {2'd0, ent.width};
        e_color = ent.color;
        e_link  = ent.link;
        e_last  = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= twwc_pkg::S_IDLE;
      fill      <= '0;
      column    <= '0;
      colm      <= '0;
      sent      <= '0;
      sar       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (emit && state != twwc_pkg::S_ENDC) sent <= sent + 32'd1;
      if (state == twwc_pkg::S_MARK && can_emit) sar <= sent + 32'd1;
      if (state == twwc_pkg::S_ROUTE && store_case && state_next == twwc_pkg::S_IDLE) begin
        fill <= fill + 1'b1;
      end
      if (state == twwc_pkg::S_FINAL && can_emit) begin
        fill <= '0;
        if (ent.kind == twwc_pkg::K_NL[1:0]) begin
          column <= '0;
          colm   <= '0;
        end else if (x_fin > {2'd0, twwc_pkg::COL_MAX}) begin
          column <= twwc_pkg::COL_MAX;
          colm   <= SAT_MOD;
        end else begin
          column <= x_fin[9:0];
          colm   <= mod_add(xm, {2'd0, ent.width});
        end
      end
    end
  end

  // flush walk, buffer and output payload
  always_ff @(posedge clk) begin
    if (q_pop) ent <= q_data;
    if (state == twwc_pkg::S_ROUTE) begin
      if (store_case) begin
        buf_q[fill[AW-1:0]] <= '{code: ent.code, width: ent.width,
                                 color: ent.color, link: ent.link};
      end
      i   <= '0;
      nxt <= '0;
      x   <= {2'd0, column};
      xm  <= colm;
    end
    if (state == twwc_pkg::S_TOP) begin
      j <= i + 1'b1;
      s <= '0;
    end
    if (state == twwc_pkg::S_LOOK && j < fill) begin
      if (!twwc_pkg::is_ws(rd.code)) j <= j + 1'b1;
      s <= s + {6'd0, rd.width};
    end
    if (state == twwc_pkg::S_DECIDE) begin
      skip <= (j < fill) && twwc_pkg::is_ws(rd.code);
      if (!brk) nxt <= j;
    end
    if (state == twwc_pkg::S_BRK && can_emit) begin
      x   <= '0;
      xm  <= '0;
      nxt <= skip ? i : j;
      if (skip) i <= i + 1'b1;
    end
    if (state == twwc_pkg::S_CELL && can_emit) begin
      i  <= i + 1'b1;
      x  <= x_cell;
      xm <= rd_tab ? 4'd0 : mod_add(xm, cell_w);
    end
    if (state == twwc_pkg::S_POST && can_emit) begin
      x  <= '0;
      xm <= '0;
    end
    if (emit) begin
      out_kind  <= e_kind;
      out_code  <= e_code;
      out_width <= e_width;
      out_color <= e_color;
      out_link  <= e_link;
      out_last  <= e_last;
    end
  end

endmodule

// ===== src/terminal_word_wrap_cell_emitter_top.sv =====
// ----------------------------------------------------------------------------
// terminal_word_wrap_cell_emitter_top
// word wrapping terminal cell emitter with tab expansion and reset markers
// ----------------------------------------------------------------------------
//  channel  direction  handshake               payload
//  input    in         in_valid / in_stall     cell_kind .. doc_position
//  output   out        out_valid / out_stall   out_kind .. out_last
//  config   in         cfg_we                  cfg_index, cfg_data
//
//  a buffered ordinary cell holds the back part through pop, marker check and
//  route, plus a marker state when a reset marker goes out first
//  a flush runs a walk step and an emit per buffered cell, a look-ahead step
//  per slot, a decide per word and a break state per line break, then the
//  closing cell (an end cell adds an end state); every emit waits out out_stall
//  reset clears the fill count, column and counters; the buffer is not cleared
//  a two-entry queue keeps accepting until full while the back part waits on out_stall
// ----------------------------------------------------------------------------
module terminal_word_wrap_cell_emitter_top #(
  parameter int BUF_DEPTH = twwc_pkg::BUF_DEPTH_DEF,
  parameter int TAB_STOP  = twwc_pkg::TAB_STOP_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  cell_kind,
  input  logic [20:0] code_point,
  input  logic [1:0]  cell_width,
  input  logic [7:0]  cell_color,
  input  logic [31:0] cell_link,
  input  logic [31:0] doc_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [31:0] out_code,
  output logic [3:0]  out_width,
  output logic [7:0]  out_color,
  output logic [31:0] out_link,
  output logic        out_last,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [9:0]  line_width;
  logic [15:0] reset_interval;
  logic        q_valid, q_pop;
  twwc_pkg::entry_t  q_data;
  twwc_pkg::status_t status;

  // configuration registers; written only while idle by the user, the block itself does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= 10'd80;
      reset_interval <= 16'd512;
    end else if (cfg_we) begin
      case (cfg_index)
        twwc_pkg::REG_LINE_WIDTH: line_width     <= cfg_data[9:0];
        twwc_pkg::REG_INTERVAL:   reset_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept and classify each transaction
  twwc_front u_front (
    .clk, .rst, .in_valid, .in_stall, .cell_kind, .code_point, .cell_width,
    .cell_color, .cell_link, .doc_position, .q_valid, .q_data, .q_pop
  );

  // back: buffering, flush walk and output register
  twwc_back #(.BUF_DEPTH(BUF_DEPTH), .TAB_STOP(TAB_STOP)) u_back (
    .clk, .rst, .q_valid, .q_data, .q_pop, .line_width, .reset_interval,
    .out_valid, .out_stall, .out_kind, .out_code, .out_width, .out_color,
    .out_link, .out_last, .status
  );

  // end cells always close the results of their transaction
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == twwc_pkg::K_END |-> out_last)
    else $error("end cell without last flag");

  a_mark_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind == twwc_pkg::K_MARK |-> out_width == 4'd0 && out_color == 8'd0)
    else $error("reset marker with nonzero width or color");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    status.fill <= 5'(BUF_DEPTH))
    else $error("buffer fill beyond depth");

  a_idle_queue: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> status.busy)
    else $error("popped transaction not taken by back part");

endmodule

// ===== test/terminal_word_wrap_cell_emitter_top_tb.sv =====
// ----------------------------------------------------------------------------
// terminal_word_wrap_cell_emitter_top_tb
// self-checking bench for the word wrap cell emitter: a directed table and
// random lines of words run against an in-bench wrap predictor under several
// line widths and marker intervals, with random idling on both channels
// ----------------------------------------------------------------------------
module terminal_word_wrap_cell_emitter_top_tb;

  localparam int DEPTH      = twwc_pkg::BUF_DEPTH_DEF;
  localparam int STOP       = twwc_pkg::TAB_STOP_DEF;
  localparam int WATCHDOG   = 20000;
  localparam int SETTLE     = 40;
  localparam int MAX_REPORT = 10;
  localparam int N_PHASES   = 7;
  localparam int PHASE_ITEMS = 25;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  cell_kind;
  logic [20:0] code_point;
  logic [1:0]  cell_width;
  logic [7:0]  cell_color;
  logic [31:0] cell_link;
  logic [31:0] doc_position;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_kind;
  logic [31:0] out_code;
  logic [3:0]  out_width;
  logic [7:0]  out_color;
  logic [31:0] out_link;
  logic        out_last;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  terminal_word_wrap_cell_emitter_top dut (.*);

  always #4 clk = ~clk;

  // one emitted terminal cell
  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] code;
    logic [3:0]  width;
    logic [7:0]  color;
    logic [31:0] link;
    logic        last;
  } term_cell_t;

  // one row of the directed table; typed rows carry a single known result
  typedef struct packed {
    logic [1:0]  kind;
    logic [20:0] code;
    logic [1:0]  width;
    logic [7:0]  color;
    logic [31:0] link;
    logic [31:0] pos;
    logic        typed;
  } stim_row_t;

  term_cell_t expected_cells[$];
  term_cell_t step_cells[$];

  // predictor copy of the block state and registers
  logic [31:0] wrap_width;
  logic [31:0] mark_interval;
  logic [31:0] held_code [DEPTH];
  logic [31:0] held_width[DEPTH];
  logic [31:0] held_color[DEPTH];
  logic [31:0] held_link [DEPTH];
  logic [31:0] held_fill;
  logic [31:0] cur_column;
  logic [31:0] sent_cells;
  logic [31:0] sent_at_mark;

  int  mismatches = 0;
  int  idle_cycles;
  int  stall_left;
  bit  quiet = 1'b0;

  function automatic bit white_char(input logic [31:0] c);
    return c == 32'(twwc_pkg::CH_SPACE) || c == 32'(twwc_pkg::CH_TAB) ||
           c == 32'(twwc_pkg::CH_NL);
  endfunction

  task automatic push_cell(input logic [31:0] k, input logic [31:0] c,
                           input logic [31:0] w, input logic [31:0] col,
                           input logic [31:0] l);
    term_cell_t t;
    t.kind  = k[2:0];
    t.code  = c;
    t.width = w[3:0];
    t.color = col[7:0];
    t.link  = l;
    t.last  = 1'b0;
    step_cells.push_back(t);
  endtask

  task automatic break_line();
    sent_cells++;
    push_cell(32'(twwc_pkg::K_NL), 0, 0, 0, 0);
  endtask

  // handle one cell: marker check, blank pass-through, buffering or flush
  task automatic wrap_cell(input logic [31:0] kind, input logic [31:0] code,
                           input logic [31:0] width, input logic [31:0] color,
                           input logic [31:0] link, input logic [31:0] pos);
    logic [31:0] i, j, x, nx, nxt;
    if (sent_cells != 0 && (sent_cells - sent_at_mark) >= mark_interval) begin
      push_cell(32'(twwc_pkg::K_MARK), pos, 0, 0, sent_cells);
      sent_cells++;
      sent_at_mark = sent_cells;
    end
    // code point ten always turns into a bare newline
    if (code == 32'(twwc_pkg::CH_NL)) begin
      kind = 32'(twwc_pkg::K_NL); code = 0; width = 0; color = 0; link = 0;
    end
    if (kind == 32'(twwc_pkg::K_BLANK)) begin
      sent_cells++;
      push_cell(32'(twwc_pkg::K_BLANK), code, width, color, link);
      return;
    end
    if (kind == 32'(twwc_pkg::K_ORD) && held_fill < DEPTH) begin
      held_code[held_fill]  = code;
      held_width[held_fill] = width;
      held_color[held_fill] = color;
      held_link[held_fill]  = link;
      held_fill++;
      return;
    end
    nxt = 0;
    x = cur_column;
    for (i = 0; i < held_fill; i++) begin
      if (i >= nxt) begin
        // look ahead to the end of the word; past the fill is not whitespace
        j = i + 1;
        nx = x;
        while (j < held_fill) begin
          nx += held_width[j];
          if (held_code[j] == 32'(twwc_pkg::CH_HYPHEN)) begin
            j++;
            break;
          end
          if (white_char(held_code[j])) break;
          j++;
        end
        if (nx - x <= wrap_width && nx >= wrap_width) begin
          break_line();
          x = 0;
          nxt = i;
          if (j < held_fill && white_char(held_code[j])) continue;
        end
        nxt = j;
      end
      if (held_code[i] == 32'(twwc_pkg::CH_TAB)) begin
        held_width[i] = STOP - (x % STOP);
        held_code[i]  = 32'(twwc_pkg::CH_SPACE);
      end
      x += held_width[i];
      sent_cells++;
      push_cell(32'(twwc_pkg::K_ORD), held_code[i], held_width[i], held_color[i],
                held_link[i]);
      if (x >= wrap_width) begin
        break_line();
        x = 0;
      end
    end
    if (kind == 32'(twwc_pkg::K_NL)) x = 0;
    else x += width;
    cur_column = (x > 32'(twwc_pkg::COL_MAX)) ? 32'(twwc_pkg::COL_MAX) : x;
    held_fill = 0;
    sent_cells++;
    push_cell(kind, code, width, color, link);
  endtask

  // expected cells of one accepted transaction, in step_cells
  task automatic predict_cells(input stim_row_t r);
    step_cells.delete();
    if (r.kind == twwc_pkg::K_END[1:0]) begin
      wrap_cell(32'(twwc_pkg::K_NL), 0, 0, 0, 0, held_fill);
      push_cell(32'(twwc_pkg::K_END), 32'(r.code), 32'(r.width), 32'(r.color), r.link);
    end else begin
      wrap_cell(32'(r.kind), 32'(r.code), 32'(r.width), 32'(r.color), r.link, r.pos);
    end
    if (step_cells.size() > 0) step_cells[step_cells.size() - 1].last = 1'b1;
  endtask

  // drive one transaction, wait for acceptance, then record its results
  task automatic send_cell(input stim_row_t r);
    term_cell_t t;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    cell_kind    <= r.kind;
    code_point   <= r.code;
    cell_width   <= r.width;
    cell_color   <= r.color;
    cell_link    <= r.link;
    doc_position <= r.pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_cells(r);
    if (r.typed) begin
      // single known result: code ten gives a bare newline, else a blank
      if (r.code == twwc_pkg::CH_NL) t = '{kind: twwc_pkg::K_NL, default: '0};
      else t = '{twwc_pkg::K_BLANK, 32'(r.code), 4'(r.width), r.color, r.link, 1'b0};
      t.last = 1'b1;
      expected_cells.push_back(t);
    end else begin
      foreach (step_cells[k]) expected_cells.push_back(step_cells[k]);
    end
  endtask

  // sender holds off until the block has delivered everything
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == twwc_pkg::REG_LINE_WIDTH) wrap_width = 32'(value[9:0]);
    else mark_interval = 32'(value);
  endtask

  // random cell: mostly words and line ends, some noise
  function automatic stim_row_t random_cell(input bit line_end);
    stim_row_t r;
    int pick;
    r.color = 8'($urandom);
    r.link  = $urandom;
    r.pos   = $urandom;
    r.typed = 1'b0;
    r.kind  = twwc_pkg::K_ORD[1:0];
    r.width = 2'd1;
    r.code  = 21'($urandom_range(97, 122));
    pick = $urandom_range(0, 99);
    if (line_end) begin
      if (pick < 70) begin
        r.kind = twwc_pkg::K_NL[1:0];
        r.code = (pick < 15) ? twwc_pkg::CH_NL : 21'($urandom);
        r.width = 2'($urandom);
      end else if (pick < 85) begin
        r.kind = twwc_pkg::K_END[1:0];
        r.code = 21'($urandom);
        r.width = 2'($urandom);
      end else begin
        r.code = twwc_pkg::CH_NL;
      end
    end else if (pick < 12) r.code = twwc_pkg::CH_SPACE;
    else if (pick < 18) r.code = twwc_pkg::CH_TAB;
    else if (pick < 24) r.code = twwc_pkg::CH_HYPHEN;
    else if (pick < 30) begin
      r.code = 21'($urandom);
      r.width = 2'($urandom);
    end else if (pick < 34) begin
      r.kind = twwc_pkg::K_BLANK[1:0];
      r.code = 21'($urandom);
      r.width = 2'($urandom);
    end else if (pick < 36) begin
      r.kind = 2'($urandom);
      r.code = 21'($urandom);
      r.width = 2'($urandom);
    end else if (pick < 42) r.width = 2'd2;
    return r;
  endfunction

  // directed table: extremes, each kind, tab, hyphen, wide cells, code ten
  stim_row_t directed [19] = '{
    '{twwc_pkg::K_BLANK[1:0], 21'h1FFFFF, 2'd3, 8'hFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b1},
    '{twwc_pkg::K_BLANK[1:0], 21'h0, 2'd0, 8'h00, 32'h0, 32'h0, 1'b1},
    '{twwc_pkg::K_ORD[1:0], twwc_pkg::CH_NL, 2'd2, 8'hAA, 32'h1234, 32'h5, 1'b1},
    '{twwc_pkg::K_END[1:0], 21'h1FFFFF, 2'd3, 8'hFF, 32'hFFFFFFFF, 32'h0, 1'b0},
    '{twwc_pkg::K_ORD[1:0], 21'd104, 2'd1, 8'h01, 32'h11, 32'h0, 1'b0},
    '{twwc_pkg::K_ORD[1:0], twwc_pkg::CH_TAB, 2'd1, 8'h02, 32'h22, 32'h0, 1'b0},
    '{twwc_pkg::K_ORD[1:0], twwc_pkg::CH_HYPHEN, 2'd1, 8'h03, 32'h33, 32'h0, 1'b0},
    '{twwc_pkg::K_ORD[1:0], twwc_pkg::CH_SPACE, 2'd1, 8'h04, 32'h44, 32'h0, 1'b0},
    '{twwc_pkg::K_ORD[1:0], 21'h4E2D, 2'd2, 8'h05, 32'h55, 32'h0, 1'b0},
    '{twwc_pkg::K_ORD[1:0], 21'h1FFFFF, 2'd3, 8'hFF, 32'hFFFFFFFF, 32'h0, 1'b0},
    '{twwc_pkg::K_NL[1:0], 21'd0, 2'd1, 8'h06, 32'h66, 32'h7, 1'b0},
    '{twwc_pkg::K_ORD[1:0], 21'd97, 2'd1, 8'h07, 32'h77, 32'h0, 1'b0},
    '{twwc_pkg::K_ORD[1:0], 21'd98, 2'd1, 8'h08, 32'h88, 32'h0, 1'b0},
    '{twwc_pkg::K_ORD[1:0], 21'd99, 2'd0, 8'h09, 32'h99, 32'h0, 1'b0},
    '{twwc_pkg::K_END[1:0], 21'd0, 2'd0, 8'h00, 32'h0, 32'hFFFFFFFF, 1'b0},
    '{twwc_pkg::K_BLANK[1:0], twwc_pkg::CH_NL, 2'd1, 8'h0A, 32'hAA, 32'h0, 1'b1},
    '{twwc_pkg::K_ORD[1:0], 21'd120, 2'd2, 8'h0B, 32'hBB, 32'h0, 1'b0},
    '{twwc_pkg::K_NL[1:0], twwc_pkg::CH_NL, 2'd3, 8'hFF, 32'hFFFFFFFF, 32'h0, 1'b0},
    '{twwc_pkg::K_END[1:0], 21'd65, 2'd1, 8'h0C, 32'hCC, 32'h0, 1'b0}
  };

  // line width and marker interval per phase, extremes included
  logic [15:0] phase_width   [N_PHASES] = '{16'd1, 16'd1023, 16'd0, 16'd12, 16'd20,
                                            16'd8, 16'd80};
  logic [15:0] phase_interval[N_PHASES] = '{16'd1, 16'd65535, 16'd0, 16'd7, 16'd40,
                                            16'd3, 16'd512};

  // stimulus
  initial begin
    int words;
    rst = 1'b1;
    in_valid = 1'b0;
    cell_kind = '0;
    code_point = '0;
    cell_width = '0;
    cell_color = '0;
    cell_link = '0;
    doc_position = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    wrap_width = 80;
    mark_interval = 512;
    held_fill = 0;
    cur_column = 0;
    sent_cells = 0;
    sent_at_mark = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[k]) send_cell(directed[k]);

    for (int p = 0; p < N_PHASES; p++) begin
      drain();
      write_reg(twwc_pkg::REG_LINE_WIDTH, phase_width[p]);
      write_reg(twwc_pkg::REG_INTERVAL, phase_interval[p]);
      // last phase runs with no idling on either side
      if (p == N_PHASES - 1) quiet = 1'b1;
      words = 0;
      while (words < PHASE_ITEMS) begin
        // a line of up to a little more than the buffer, then its end
        repeat ($urandom_range(0, DEPTH + 6)) begin
          send_cell(random_cell(1'b0));
          words++;
        end
        send_cell(random_cell(1'b1));
        words++;
      end
    end
    drain();
    if (mismatches == 0 && expected_cells.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // receiver idling in random bursts
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_stall  <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // compare each result transaction with the oldest expected cell
  always @(posedge clk) begin
    term_cell_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{out_kind, out_code, out_width, out_color, out_link, out_last};
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORT) $display("unexpected cell %p", got);
      end else begin
        want = expected_cells.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORT) $display("cell mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
